[hw/rtl/park_rotation_top_macros.svh]
// Assertion macros shared by the park rotation checker.
`ifndef PARK_ROTATION_TOP_MACROS_SVH
`define PARK_ROTATION_TOP_MACROS_SVH

// Concurrent check, ignored while reset is asserted.
`define PRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define PRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/prc_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the park rotation block.
`timescale 1ns / 1ps

package prc_pkg;

  // CORDIC datapath width: Q2.30 values with headroom.
  localparam int CORDIC_W = 34;
  localparam int FRAC_BITS = 30;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int MAX_STAGES = 32;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic  valid;
    logic  mode;
    quad_t quad;
  } ctl_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
    case (idx)
      0:  return 34'sd536870912;
      1:  return 34'sd316933406;
      2:  return 34'sd167458907;
      3:  return 34'sd85004756;
      4:  return 34'sd42667331;
      5:  return 34'sd21354465;
      6:  return 34'sd10679838;
      7:  return 34'sd5340245;
      8:  return 34'sd2670163;
      9:  return 34'sd1335087;
      10: return 34'sd667544;
      11: return 34'sd333772;
      12: return 34'sd166886;
      13: return 34'sd83443;
      14: return 34'sd41722;
      15: return 34'sd20861;
      16: return 34'sd10430;
      17: return 34'sd5215;
      18: return 34'sd2608;
      19: return 34'sd1304;
      20: return 34'sd652;
      21: return 34'sd326;
      22: return 34'sd163;
      23: return 34'sd81;
      24: return 34'sd41;
      25: return 34'sd20;
      26: return 34'sd10;
      27: return 34'sd5;
      28: return 34'sd3;
      29: return 34'sd1;
      30: return 34'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

[hw/rtl/prc_cell.sv]
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE), registered, with side data.
`timescale 1ns / 1ps

module prc_cell #(
  parameter int DATA_BITS = 16,
  parameter int STAGE     = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  prc_pkg::ctl_t                         ctl_in,
  input  logic signed [DATA_BITS-1:0]           vx_in,
  input  logic signed [DATA_BITS-1:0]           vy_in,
  input  logic signed [prc_pkg::CORDIC_W-1:0]   x_in,
  input  logic signed [prc_pkg::CORDIC_W-1:0]   y_in,
  input  logic signed [prc_pkg::CORDIC_W-1:0]   z_in,
  output prc_pkg::ctl_t                         ctl_out,
  output logic signed [DATA_BITS-1:0]           vx_out,
  output logic signed [DATA_BITS-1:0]           vy_out,
  output logic signed [prc_pkg::CORDIC_W-1:0]   x_out,
  output logic signed [prc_pkg::CORDIC_W-1:0]   y_out,
  output logic signed [prc_pkg::CORDIC_W-1:0]   z_out
);

  localparam logic signed [prc_pkg::CORDIC_W-1:0] ATAN = prc_pkg::atan_turn(STAGE);

  logic signed [prc_pkg::CORDIC_W-1:0] dx;
  logic signed [prc_pkg::CORDIC_W-1:0] dy;
  logic signed [prc_pkg::CORDIC_W-1:0] x_next;
  logic signed [prc_pkg::CORDIC_W-1:0] y_next;
  logic signed [prc_pkg::CORDIC_W-1:0] z_next;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_comb begin
    if (!z_in[prc_pkg::CORDIC_W-1]) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_out <= vx_in;
      vy_out <= vy_in;
      x_out  <= x_next;
      y_out  <= y_next;
      z_out  <= z_next;
    end
  end

endmodule

[hw/rtl/prc_post.sv]
// Quadrant mapping, component products, rounding and saturation into the output register.
`timescale 1ns / 1ps

module prc_post #(
  parameter int DATA_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  prc_pkg::ctl_t                         ctl_in,
  input  logic signed [DATA_BITS-1:0]           vx_in,
  input  logic signed [DATA_BITS-1:0]           vy_in,
  input  logic signed [prc_pkg::CORDIC_W-1:0]   x_in,
  input  logic signed [prc_pkg::CORDIC_W-1:0]   y_in,
  output logic                                  valid,
  output logic signed [DATA_BITS-1:0]           rot_x,
  output logic signed [DATA_BITS-1:0]           rot_y,
  output logic                                  clipped
);

  localparam int CW = prc_pkg::CORDIC_W;
  localparam int PW = DATA_BITS + CW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (prc_pkg::FRAC_BITS - 1));
  localparam logic signed [SW-1:0] HI   = SW'(signed'((64'd1 << (DATA_BITS - 1)) - 64'd1));
  localparam logic signed [SW-1:0] LO   = -HI - SW'(1);

  logic signed [CW-1:0] c_sel;
  logic signed [CW-1:0] s_sel;

  logic                 a_valid;
  logic                 a_mode;
  logic signed [PW-1:0] p_xc;
  logic signed [PW-1:0] p_ys;
  logic signed [PW-1:0] p_xs;
  logic signed [PW-1:0] p_yc;

  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] rnd_x;
  logic signed [SW-1:0] rnd_y;
  logic signed [DATA_BITS-1:0] sat_x;
  logic signed [DATA_BITS-1:0] sat_y;
  logic                 clip_x;
  logic                 clip_y;

  always_comb begin
    case (ctl_in.quad)
      prc_pkg::QUAD_0: begin
        c_sel = x_in;
        s_sel = y_in;
      end
      prc_pkg::QUAD_90: begin
        c_sel = -y_in;
        s_sel = x_in;
      end
      prc_pkg::QUAD_180: begin
        c_sel = -x_in;
        s_sel = -y_in;
      end
      default: begin
        c_sel = y_in;
        s_sel = -x_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= ctl_in.mode;
      p_xc   <= vx_in * c_sel;
      p_ys   <= vy_in * s_sel;
      p_xs   <= vx_in * s_sel;
      p_yc   <= vy_in * c_sel;
    end
  end

  // forward: x*c + y*s, y*c - x*s; inverse: x*c - y*s, x*s + y*c
  always_comb begin
    if (a_mode) begin
      sum_x = SW'(p_xc) - SW'(p_ys);
      sum_y = SW'(p_xs) + SW'(p_yc);
    end else begin
      sum_x = SW'(p_xc) + SW'(p_ys);
      sum_y = SW'(p_yc) - SW'(p_xs);
    end
    rnd_x = (sum_x + HALF) >>> prc_pkg::FRAC_BITS;
    rnd_y = (sum_y + HALF) >>> prc_pkg::FRAC_BITS;
    clip_x = (rnd_x > HI) || (rnd_x < LO);
    clip_y = (rnd_y > HI) || (rnd_y < LO);
    if (rnd_x > HI) begin
      sat_x = HI[DATA_BITS-1:0];
    end else if (rnd_x < LO) begin
      sat_x = LO[DATA_BITS-1:0];
    end else begin
      sat_x = rnd_x[DATA_BITS-1:0];
    end
    if (rnd_y > HI) begin
      sat_y = HI[DATA_BITS-1:0];
    end else if (rnd_y < LO) begin
      sat_y = LO[DATA_BITS-1:0];
    end else begin
      sat_y = rnd_y[DATA_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x   <= sat_x;
      rot_y   <= sat_y;
      clipped <= clip_x || clip_y;
    end
  end

endmodule

[hw/rtl/park_rotation_top.sv]
// Top level of the forward / inverse Park rotation with a pipelined CORDIC.
// Usage:
//   Input stream s_axis_*: one word per vector. tdata carries vec_x, vec_y and
//   the angle (65536 per turn); tuser carries the mode bit (0 forward Park,
//   rotate by minus the angle; 1 inverse Park, rotate by plus the angle).
//   Output stream m_axis_*: one word per input word, in order. tdata carries
//   rot_x and rot_y (saturated); tuser is set when either was saturated.
//   Throughput: one word per cycle. The CORDIC is a row of min(CORDIC_STAGES,32)
//   registered cells, followed by a product stage and a rounding stage.
//   Stall: the whole pipeline advances together; while a finished word sits in
//   the output register and m_axis_tready is low, the pipeline holds and
//   s_axis_tready is low. With the output register empty or being taken, a new
//   word is accepted every cycle.
//   Reset (rst, synchronous, active high) empties the pipeline; no state is kept
//   between words.
`timescale 1ns / 1ps

module park_rotation_top #(
  parameter int DATA_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // vec_x, vec_y, angle[15:0], zero padding
  input  logic [((2*DATA_BITS+16+7)/8)*8-1:0]            s_axis_tdata,
  // mode
  input  logic                                           s_axis_tuser,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // rot_x, rot_y, zero padding
  output logic [((2*DATA_BITS+7)/8)*8-1:0]               m_axis_tdata,
  // clipped
  output logic                                           m_axis_tuser
);

  localparam int N     = (CORDIC_STAGES > prc_pkg::MAX_STAGES) ?
                         prc_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int CW    = prc_pkg::CORDIC_W;
  localparam int OUT_W = ((2*DATA_BITS+7)/8)*8;

  logic                        en;
  logic [15:0]                 angle;
  logic [15:0]                 ang_sum;
  logic [15:0]                 resid;
  logic signed [CW-1:0]        z0;

  prc_pkg::ctl_t               ctl_c [0:N];
  logic signed [DATA_BITS-1:0] vx_c  [0:N];
  logic signed [DATA_BITS-1:0] vy_c  [0:N];
  logic signed [CW-1:0]        x_c   [0:N];
  logic signed [CW-1:0]        y_c   [0:N];
  logic signed [CW-1:0]        z_c   [0:N];

  logic signed [DATA_BITS-1:0] rot_x;
  logic signed [DATA_BITS-1:0] rot_y;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // quadrant split: residual angle in [-1/8, 1/8) turn
  assign angle   = s_axis_tdata[2*DATA_BITS +: 16];
  assign ang_sum = angle + 16'h2000;
  assign resid   = angle - {ang_sum[15:14], 14'd0};
  assign z0      = {{(CW-32){resid[15]}}, resid, 16'd0};

  assign ctl_c[0] = '{valid: s_axis_tvalid, mode: s_axis_tuser,
                      quad: prc_pkg::quad_t'(ang_sum[15:14])};
  assign vx_c[0]  = s_axis_tdata[DATA_BITS-1:0];
  assign vy_c[0]  = s_axis_tdata[2*DATA_BITS-1:DATA_BITS];
  assign x_c[0]   = prc_pkg::GAIN_Q30;
  assign y_c[0]   = '0;
  assign z_c[0]   = z0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    prc_cell #(
      .DATA_BITS (DATA_BITS),
      .STAGE     (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_c[i]),
      .vx_in   (vx_c[i]),
      .vy_in   (vy_c[i]),
      .x_in    (x_c[i]),
      .y_in    (y_c[i]),
      .z_in    (z_c[i]),
      .ctl_out (ctl_c[i+1]),
      .vx_out  (vx_c[i+1]),
      .vy_out  (vy_c[i+1]),
      .x_out   (x_c[i+1]),
      .y_out   (y_c[i+1]),
      .z_out   (z_c[i+1])
    );
  end

  prc_post #(
    .DATA_BITS (DATA_BITS)
  ) u_post (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_c[N]),
    .vx_in   (vx_c[N]),
    .vy_in   (vy_c[N]),
    .x_in    (x_c[N]),
    .y_in    (y_c[N]),
    .valid   (m_axis_tvalid),
    .rot_x   (rot_x),
    .rot_y   (rot_y),
    .clipped (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({rot_y, rot_x});

endmodule

[hw/rtl/prc_checker.sv]
// Port-level checker for the park rotation top level, attached by bind.
`timescale 1ns / 1ps
`include "park_rotation_top_macros.svh"

module prc_checker #(
  parameter int DATA_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((2*DATA_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  localparam logic [DATA_BITS-1:0] MAXV = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic [DATA_BITS-1:0] MINV = {1'b1, {(DATA_BITS-1){1'b0}}};

  logic [DATA_BITS-1:0] out_x;
  logic [DATA_BITS-1:0] out_y;
  logic                 at_limit;

  assign out_x    = m_axis_tdata[DATA_BITS-1:0];
  assign out_y    = m_axis_tdata[2*DATA_BITS-1:DATA_BITS];
  assign at_limit = (out_x == MAXV) || (out_x == MINV) || (out_y == MAXV) || (out_y == MINV);

  `PRC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  `PRC_ASSERT(a_ready_rule, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "bad input ready")

  `PRC_ASSERT(a_hold_word, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

  `PRC_ASSERT(a_clip_limit, m_axis_tvalid && m_axis_tuser |-> at_limit, "clip flag without a saturated component")

endmodule

bind park_rotation_top prc_checker #(.DATA_BITS(DATA_BITS)) u_prc_checker (.*);
